>>> design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; clock and reset are passed by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, disabled during reset.
`define AMR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same, written as antecedent and next-cycle consequent.
`define AMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  `AMR_ASSERT(label, clk, rst, (ante) |=> (cons), msg)

`endif

>>> design/amr_sfs_pkg.sv
// Types, constants and table functions for the AMR storage frame scanner.
// No dependencies.
package amr_sfs_pkg;

  localparam int SUM_BITS       = 48;
  localparam int MIN_FILE_BYTES = 15;
  localparam int NB_LAST_IDX    = 5;
  localparam int WB_LAST_IDX    = 8;
  localparam int DUR_BITS       = 37;
  localparam int OUT_BITS       = 136;

  localparam logic [13:0] RATE_NB = 14'd8000;
  localparam logic [13:0] RATE_WB = 14'd16000;
  localparam logic [14:0] AVG_MAX = 15'd23850;
  localparam logic [DUR_BITS-1:0] DUR_MAX = '1;

  // bit 0 NB, bit 1 WB, bit 2 NB multichannel, bit 3 WB multichannel
  localparam logic [3:0] FLAGS_ALL = 4'hF;
  localparam logic [3:0] FLAGS_MC  = 4'hC;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_SHORT   = 2'd1,
    STAT_UNKNOWN = 2'd2,
    STAT_MULTI   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [14:0] rate;
    logic [5:0]  len;
  } mode_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic mode_entry_t mode_lookup(input logic wide, input logic [3:0] mode);
    mode_entry_t m;
    case ({wide, mode})
      5'h00: m = '{15'd4750,  6'd13};
      5'h01: m = '{15'd5150,  6'd14};
      5'h02: m = '{15'd5900,  6'd16};
      5'h03: m = '{15'd6700,  6'd18};
      5'h04: m = '{15'd7400,  6'd20};
      5'h05: m = '{15'd7950,  6'd21};
      5'h06: m = '{15'd10200, 6'd27};
      5'h07: m = '{15'd12200, 6'd32};
      5'h08: m = '{15'd0,     6'd6};
      5'h10: m = '{15'd6600,  6'd18};
      5'h11: m = '{15'd8850,  6'd24};
      5'h12: m = '{15'd12650, 6'd33};
      5'h13: m = '{15'd14250, 6'd37};
      5'h14: m = '{15'd15850, 6'd41};
      5'h15: m = '{15'd18250, 6'd47};
      5'h16: m = '{15'd19850, 6'd51};
      5'h17: m = '{15'd23050, 6'd59};
      5'h18: m = '{15'd23850, 6'd61};
      5'h19: m = '{15'd0,     6'd6};
      5'h1A: m = '{15'd0,     6'd6};
      default: m = '{15'd0,   6'd1};
    endcase
    return m;
  endfunction

  // "#!AMR-WB_MC1.0\n"; the WB prefix shares its first eight bytes
  function automatic logic [7:0] magic_wb_mc(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:  c = "#";
      4'd1:  c = "!";
      4'd2:  c = "A";
      4'd3:  c = "M";
      4'd4:  c = "R";
      4'd5:  c = "-";
      4'd6:  c = "W";
      4'd7:  c = "B";
      4'd8:  c = "_";
      4'd9:  c = "M";
      4'd10: c = "C";
      4'd11: c = "1";
      4'd12: c = ".";
      4'd13: c = "0";
      default: c = 8'h0A;
    endcase
    return c;
  endfunction

  // "#!AMR_MC1.0\n"; the NB prefix shares its first five bytes
  function automatic logic [7:0] magic_nb_mc(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd5:  c = "_";
      4'd6:  c = "M";
      4'd7:  c = "C";
      4'd8:  c = "1";
      4'd9:  c = ".";
      4'd10: c = "0";
      4'd11: c = 8'h0A;
      default: c = magic_wb_mc(idx);
    endcase
    return c;
  endfunction

  // mask of prefixes not contradicted by byte b at position idx
  function automatic logic [3:0] prefix_keep(input logic [3:0] idx, input logic [7:0] b);
    logic [3:0] k;
    k = FLAGS_ALL;
    if (idx < 4'd5 && magic_wb_mc(idx) != b) k = 4'h0;
    if (idx == 4'd5 && b != 8'h0A) k[0] = 1'b0;
    if (idx >= 4'd5 && idx < 4'd8 && magic_wb_mc(idx) != b) k[1] = 1'b0;
    if (idx == 4'd8 && b != 8'h0A) k[1] = 1'b0;
    if (idx >= 4'd5 && idx < 4'd12 && magic_nb_mc(idx) != b) k[2] = 1'b0;
    if (idx >= 4'd5 && magic_wb_mc(idx) != b) k[3] = 1'b0;
    return k;
  endfunction

endpackage

>>> design/amr_sfs_div.sv
// Restoring divider, one quotient bit per cycle, for the average bitrate.
// Depends on amr_sfs_pkg.
module amr_sfs_div import amr_sfs_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SUM_BITS-1:0]   dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output div_stat_t             stat,
  output logic [SUM_BITS-1:0]   quotient
);

  localparam int CNT_W = $clog2(SUM_BITS);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [SUM_BITS-1:0]   dvd;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dsr;
  logic [COUNT_BITS+1:0] trial;
  logic                  qbit;

  always_comb begin
    trial = {1'b0, rem, dvd[SUM_BITS-1]} - {2'b00, dsr};
    qbit  = ~trial[COUNT_BITS+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[SUM_BITS-2:0], qbit};
      rem <= qbit ? trial[COUNT_BITS-1:0] : {rem[COUNT_BITS-2:0], dvd[SUM_BITS-1]};
    end
  end

  assign stat     = '{busy: busy, done: done};
  assign quotient = dvd;

endmodule

>>> design/amr_storage_frame_scanner.sv
// Top level of the AMR storage frame scanner: byte parser, summary staging,
// output register. Depends on amr_sfs_pkg and amr_sfs_div.
//
// Takes one file byte per cycle while ready is high. On the byte marked last the
// summary is staged and the block drops ready while the restoring divider forms
// the average bitrate, one quotient bit per cycle; the summary is loaded into the
// output register the cycle the divider finishes, or later if the previous
// summary has not yet been taken. Bytes of the next file are accepted while a
// summary waits in the output register.
module amr_storage_frame_scanner import amr_sfs_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] data_byte
  input  logic                s_axis_tlast,  // last_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status[1:0], is_wideband[2], file_bytes[34:3], frame_total[66:35],
  // duration_ms[103:67], average_bitrate[118:104], sample_rate[132:119], zero pad
  output logic [OUT_BITS-1:0] m_axis_tdata
);

  localparam int SUM_EXT = SUM_BITS + 1;
  localparam int DUR_W   = COUNT_BITS + 5;
  localparam int CMP_W   = (DUR_W > DUR_BITS) ? DUR_W : DUR_BITS;

  state_t state, state_next;

  // parse state
  logic [3:0]            flags, flags_next;
  logic                  settled, settled_next;
  logic                  wide, wide_next;
  logic [COUNT_BITS-1:0] byte_cnt, byte_cnt_next;
  logic [5:0]            skip, skip_next;
  logic [COUNT_BITS-1:0] frame_cnt, frame_cnt_next;
  logic [SUM_BITS-1:0]   rate_sum, rate_sum_next;
  logic [COUNT_BITS-1:0] rated, rated_next;

  mode_entry_t           mode;
  logic [SUM_EXT-1:0]    sum_ext;
  status_t               stat_now;

  // staged summary
  status_t               sum_status;
  logic                  sum_wide;
  logic [31:0]           sum_bytes;
  logic [COUNT_BITS-1:0] sum_frames;
  logic                  sum_no_rate;

  logic                  accept, accept_last, div_start, load, slot_free;
  div_stat_t             div_stat;
  logic [SUM_BITS-1:0]   quotient;

  logic [DUR_W-1:0]      dur_full;
  logic [CMP_W-1:0]      dur_cmp;
  logic [DUR_BITS-1:0]   dur;
  logic [14:0]           avg;
  logic [13:0]           srate;

  assign accept      = s_axis_tvalid & s_axis_tready;
  assign accept_last = accept & s_axis_tlast;
  assign slot_free   = ~m_axis_tvalid | m_axis_tready;

  // byte parser
  always_comb begin
    flags_next     = flags;
    settled_next   = settled;
    wide_next      = wide;
    skip_next      = skip;
    frame_cnt_next = frame_cnt;
    rate_sum_next  = rate_sum;
    rated_next     = rated;
    mode           = mode_lookup(wide, s_axis_tdata[6:3]);
    sum_ext        = {1'b0, rate_sum} + SUM_EXT'(mode.rate);
    if (settled) begin
      if (skip == 6'd0) begin
        skip_next      = mode.len - 6'd1;
        frame_cnt_next = (&frame_cnt) ? frame_cnt : frame_cnt + 1'b1;
        rate_sum_next  = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
        if (mode.rate != 15'd0) rated_next = (&rated) ? rated : rated + 1'b1;
      end else begin
        skip_next = skip - 6'd1;
      end
    end else if (byte_cnt < COUNT_BITS'(MIN_FILE_BYTES)) begin
      flags_next = flags & prefix_keep(byte_cnt[3:0], s_axis_tdata);
      if (byte_cnt == COUNT_BITS'(NB_LAST_IDX) && flags_next[0]) begin
        settled_next = 1'b1;
        wide_next    = 1'b0;
        skip_next    = 6'd0;
      end else if (byte_cnt == COUNT_BITS'(WB_LAST_IDX) && flags_next[1]) begin
        settled_next = 1'b1;
        wide_next    = 1'b1;
        skip_next    = 6'd0;
      end
    end
    byte_cnt_next = (&byte_cnt) ? byte_cnt : byte_cnt + 1'b1;

    if (byte_cnt_next < COUNT_BITS'(MIN_FILE_BYTES)) stat_now = STAT_SHORT;
    else if (settled_next)                            stat_now = STAT_OK;
    else if ((flags_next & FLAGS_MC) != 4'h0)         stat_now = STAT_MULTI;
    else                                              stat_now = STAT_UNKNOWN;
  end

  always_ff @(posedge clk) begin
    if (rst || accept_last) begin
      flags     <= FLAGS_ALL;
      settled   <= 1'b0;
      wide      <= 1'b0;
      byte_cnt  <= '0;
      skip      <= '0;
      frame_cnt <= '0;
      rate_sum  <= '0;
      rated     <= '0;
    end else if (accept) begin
      flags     <= flags_next;
      settled   <= settled_next;
      wide      <= wide_next;
      byte_cnt  <= byte_cnt_next;
      skip      <= skip_next;
      frame_cnt <= frame_cnt_next;
      rate_sum  <= rate_sum_next;
      rated     <= rated_next;
    end
  end

  // summary staging, taken with the last byte
  always_ff @(posedge clk) begin
    if (accept_last) begin
      sum_status  <= stat_now;
      sum_wide    <= (stat_now == STAT_OK) & wide_next;
      sum_bytes   <= 32'(byte_cnt_next);
      sum_frames  <= (stat_now == STAT_OK) ? frame_cnt_next : '0;
      sum_no_rate <= (stat_now != STAT_OK) || (rated_next == '0);
    end
  end

  amr_sfs_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rate_sum_next),
    .divisor  (rated_next),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // frames * 20 = frames * 16 + frames * 4
  always_comb begin
    dur_full = {sum_frames, 4'b0000} + {1'b0, sum_frames, 2'b00};
    dur_cmp  = CMP_W'(dur_full);
    dur      = (dur_cmp > CMP_W'(DUR_MAX)) ? DUR_MAX : dur_cmp[DUR_BITS-1:0];
    if (sum_no_rate)                         avg = 15'd0;
    else if (quotient > SUM_BITS'(AVG_MAX))  avg = AVG_MAX;
    else                                     avg = quotient[14:0];
    srate = sum_wide ? RATE_WB : RATE_NB;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_RUN;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN:  if (accept_last) state_next = ST_DIV;
      ST_DIV:  if (div_stat.done) state_next = slot_free ? ST_RUN : ST_HOLD;
      ST_HOLD: if (slot_free) state_next = ST_RUN;
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    load          = 1'b0;
    unique case (state)
      ST_RUN: begin
        s_axis_tready = 1'b1;
        div_start     = s_axis_tvalid & s_axis_tlast;
      end
      ST_DIV:  load = div_stat.done & slot_free;
      ST_HOLD: load = slot_free;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {3'b000, srate, avg, dur, 32'(sum_frames), sum_bytes, sum_wide,
                       sum_status};
    end
  end

endmodule

>>> design/amr_sfs_checker.sv
// Port-level checks for the AMR storage frame scanner, bound to the top level.
// Depends on assert_macros.svh and amr_sfs_pkg.
`include "assert_macros.svh"

module amr_sfs_checker import amr_sfs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OUT_BITS-1:0] m_axis_tdata
);

  logic                in_last;
  logic                out_v;
  logic                stalled;
  logic [OUT_BITS-1:0] sum_word;
  logic                ok;
  logic                wide;
  logic                no_frame_data;
  logic                srate_ok;
  logic [13:0]         srate;
  logic [14:0]         avg;

  assign in_last       = s_axis_tvalid & s_axis_tready & s_axis_tlast;
  assign out_v         = m_axis_tvalid;
  assign stalled       = m_axis_tvalid & ~m_axis_tready;
  assign sum_word      = m_axis_tdata;
  assign ok            = m_axis_tdata[1:0] == STAT_OK;
  assign wide          = m_axis_tdata[2];
  assign srate         = m_axis_tdata[132:119];
  assign avg           = m_axis_tdata[118:104];
  assign srate_ok      = srate == (wide ? RATE_WB : RATE_NB);
  // frames, duration and average all zero, narrowband
  assign no_frame_data = !wide && (m_axis_tdata[66:35] == '0) && (m_axis_tdata[118:67] == '0);

  // stalled summary holds
  `AMR_ASSERT_NEXT(a_hold, clk, rst, stalled, out_v && $stable(sum_word), "stalled word changed")

  // end of file starts the divide, so the next cycle is not ready
  `AMR_ASSERT_NEXT(a_busy, clk, rst, in_last, !s_axis_tready, "ready right after last byte")

  // sample rate follows the format flag
  `AMR_ASSERT(a_srate, clk, rst, out_v |-> srate_ok, "sample rate does not match format")

  // failed parse gives zero frames, duration and rate
  `AMR_ASSERT(a_err_zero, clk, rst, (out_v && !ok) |-> no_frame_data, "frame data on error word")

  // average never above the top mode rate
  `AMR_ASSERT(a_avg_max, clk, rst, out_v |-> avg <= AVG_MAX, "average bitrate out of range")

endmodule

bind amr_storage_frame_scanner amr_sfs_checker u_amr_sfs_checker (.*);
